// ===== rtl/utf16_to_utf8_encoder_macros.svh =====
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

// checks outside reset
`define U2U8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checks that also hold across reset
`define U2U8_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/u2u8_pkg.sv =====
package u2u8_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int MAXB = 5;
  localparam int IDXW = 3;

  localparam logic [15:0] SUR_MASK  = 16'hF800;
  localparam logic [15:0] HALF_MASK = 16'hFC00;
  localparam logic [15:0] SUR_BASE  = 16'hD800;
  localparam logic [15:0] LOW_BASE  = 16'hDC00;
  localparam logic [15:0] MAX_1B    = 16'h007F;
  localparam logic [15:0] MAX_2B    = 16'h07FF;
  localparam logic [10:0] PLANE_ADD = 11'h040;

  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] CONT_B  = 8'h80;

  // one request's worth of output bytes, byte 0 goes out first
  typedef struct packed {
    logic [MAXB-1:0][7:0] bytes;
    logic [MAXB-1:0]      bad;
    logic [IDXW-1:0]      cnt;
  } job_t;

endpackage

// ===== rtl/u2u8_front.sv =====
module u2u8_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [15:0]      in_code_unit,
  input  logic             in_string_end,
  input  logic             q_full,
  output logic             q_push,
  output u2u8_pkg::job_t   q_data
);

  logic       pend_valid_r, pend_valid_nxt;
  logic [9:0] pend_bits_r, pend_bits_nxt;

  logic              accept;
  logic              is_sur, is_high, is_low, pair;
  logic [10:0]       plane;
  logic [2:0][7:0]   fb;
  logic [2:0]        fbad;
  logic [1:0]        fcnt;

  assign full   = q_full;
  assign accept = push && !q_full;

  assign is_sur  = (in_code_unit & u2u8_pkg::SUR_MASK) == u2u8_pkg::SUR_BASE;
  assign is_high = (in_code_unit & u2u8_pkg::HALF_MASK) == u2u8_pkg::SUR_BASE;
  assign is_low  = (in_code_unit & u2u8_pkg::HALF_MASK) == u2u8_pkg::LOW_BASE;
  assign pair    = pend_valid_r && is_low;
  assign plane   = {1'b0, pend_bits_r} + u2u8_pkg::PLANE_ADD;

  // encoding of the unit as if nothing were held
  always_comb begin
    fb   = '0;
    fbad = 3'b000;
    fcnt = 2'd0;
    if (in_code_unit <= u2u8_pkg::MAX_1B) begin
      fb[0] = in_code_unit[7:0];
      fcnt  = 2'd1;
    end else if (!is_sur) begin
      if (in_code_unit <= u2u8_pkg::MAX_2B) begin
        fb[0] = u2u8_pkg::LEAD_2B | {3'b000, in_code_unit[10:6]};
        fb[1] = u2u8_pkg::CONT_B | {2'b00, in_code_unit[5:0]};
        fcnt  = 2'd2;
      end else begin
        fb[0] = u2u8_pkg::LEAD_3B | {4'h0, in_code_unit[15:12]};
        fb[1] = u2u8_pkg::CONT_B | {2'b00, in_code_unit[11:6]};
        fb[2] = u2u8_pkg::CONT_B | {2'b00, in_code_unit[5:0]};
        fcnt  = 2'd3;
      end
    end else if (!(is_high && !in_string_end)) begin
      fbad = 3'b011;
      fcnt = 2'd2;
    end
  end

  always_comb begin
    q_data = '0;
    if (pair) begin
      q_data.bytes[0] = u2u8_pkg::LEAD_4B | {5'b00000, plane[10:8]};
      q_data.bytes[1] = u2u8_pkg::CONT_B | {2'b00, plane[7:2]};
      q_data.bytes[2] = u2u8_pkg::CONT_B | {2'b00, plane[1:0], in_code_unit[9:6]};
      q_data.bytes[3] = u2u8_pkg::CONT_B | {2'b00, in_code_unit[5:0]};
      q_data.cnt      = 3'd4;
    end else if (pend_valid_r) begin
      q_data.bytes = {fb, 16'h0000};
      q_data.bad   = {fbad, 2'b11};
      q_data.cnt   = {1'b0, fcnt} + 3'd2;
    end else begin
      q_data.bytes = {16'h0000, fb};
      q_data.bad   = {2'b00, fbad};
      q_data.cnt   = {1'b0, fcnt};
    end
  end

  assign q_push = accept && (q_data.cnt != 3'd0);

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_bits_nxt  = pend_bits_r;
    if (accept) begin
      pend_valid_nxt = is_high && !in_string_end;
      if (is_high && !in_string_end) begin
        pend_bits_nxt = in_code_unit[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_bits_r  <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      pend_bits_r  <= pend_bits_nxt;
    end
  end

endmodule

// ===== rtl/u2u8_queue.sv =====
module u2u8_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_push,
  input  u2u8_pkg::job_t   q_wdata,
  output logic             q_full,
  input  logic             q_pop,
  output logic             q_empty,
  output u2u8_pkg::job_t   q_rdata
);

  u2u8_pkg::job_t mem_r [u2u8_pkg::QDEPTH];

  logic [u2u8_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u2u8_pkg::QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [u2u8_pkg::QCW-1:0] cnt_r, cnt_nxt;
  logic                     do_push, do_pop;

  assign q_full  = cnt_r == u2u8_pkg::QCW'(u2u8_pkg::QDEPTH);
  assign q_empty = cnt_r == '0;
  assign q_rdata = mem_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == u2u8_pkg::QAW'(u2u8_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == u2u8_pkg::QAW'(u2u8_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

// ===== rtl/u2u8_back.sv =====
`include "utf16_to_utf8_encoder_macros.svh"

module u2u8_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  u2u8_pkg::job_t   q_rdata,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             out_bad_surrogate,
  output logic             out_run_last
);

  u2u8_pkg::job_t             cur_r, cur_nxt;
  logic                       cur_valid_r, cur_valid_nxt;
  logic [u2u8_pkg::IDXW-1:0]  idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r, out_byte_nxt;
  logic                       out_bad_r, out_bad_nxt;
  logic                       out_last_r, out_last_nxt;

  logic emit, is_last, load;

  assign emit    = cur_valid_r && (!out_valid_r || pop);
  assign is_last = (idx_r + 3'd1) == cur_r.cnt;
  assign load    = !q_empty && (!cur_valid_r || (emit && is_last));
  assign q_pop   = load;

  assign empty             = !out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_bad_surrogate = out_bad_r;
  assign out_run_last      = out_last_r;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_nxt       = q_rdata;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (emit && is_last) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_r.bytes[idx_r];
      out_bad_nxt   = cur_r.bad[idx_r];
      out_last_nxt  = is_last;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_bad_r  <= out_bad_nxt;
    out_last_r <= out_last_nxt;
  end

  `U2U8_ASSERT(a_idx_in_job, cur_valid_r |-> (idx_r < cur_r.cnt), "byte index past job end")
  `U2U8_ASSERT(a_job_cnt, load |=> (cur_r.cnt != 3'd0 && cur_r.cnt <= 3'd5), "bad job size")
  `U2U8_ASSERT_RST(a_rst_empty, !rst_n |=> (!out_valid_r && !cur_valid_r), "busy after reset")

endmodule

// ===== rtl/utf16_to_utf8_encoder.sv =====
// UTF-16 to UTF-8 encoder. Push one code unit per request (with an end-of-string
// flag); pop one UTF-8 byte per result, with out_run_last marking the final byte
// of each request. BMP units give 1-3 bytes, a surrogate pair 4 bytes on the low
// half (the high half alone gives none), and an unmatched surrogate two zero
// bytes flagged by out_bad_surrogate, ahead of any bytes of the unit that broke
// the pair. Output runs at one byte per cycle, while pop keeps up, from a single
// output register; a request makes 0 to 5 bytes, 4 at worst for valid text. The
// front end takes a request every cycle while the 4-entry job queue has room; a
// byte passes the job queue, the current-job register and the output register.
module utf16_to_utf8_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_code_unit,
  input  logic        in_string_end,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_bad_surrogate,
  output logic        out_run_last
);

  u2u8_pkg::job_t wjob, rjob;
  logic           q_push, q_full, q_pop, q_empty;

  u2u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_code_unit  (in_code_unit),
    .in_string_end (in_string_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (wjob)
  );

  u2u8_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (wjob),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_rdata (rjob)
  );

  u2u8_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rdata           (rjob),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_bad_surrogate (out_bad_surrogate),
    .out_run_last      (out_run_last)
  );

endmodule
